// ===== rtl/core/mdc_pkg.sv =====
package mdc_pkg;

  // Largest supported matrix order and the sizes that follow from it.
  localparam int MAX_ORDER   = 6;
  localparam int STORE_DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int MADDR_W     = 6;
  localparam int SUBSET_W    = MAX_ORDER;
  localparam int DET_DEPTH   = 1 << SUBSET_W;
  localparam int COL_W       = 3;
  localparam int ELEM_W      = 10;
  localparam int DET_W       = 64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                mat_we;
    logic [MADDR_W-1:0]  mat_waddr;
    logic [MADDR_W-1:0]  mat_raddr;
    logic [SUBSET_W-1:0] det_raddr;
    logic                use_one;
    logic                mul_en;
    logic                acc_clr;
    logic                acc_en;
    logic                acc_neg;
    logic                det_we;
    logic [SUBSET_W-1:0] det_waddr;
    logic                out_load;
  } mdc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } mdc_status_t;

endpackage

// ===== rtl/core/mdc_ram.sv =====
module mdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/mdc_dp.sv =====
module mdc_dp
  import mdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  mdc_cmd_t           cmd,
  output mdc_status_t        status,
  input  logic [ELEM_W-1:0]  elem_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DET_W-1:0]   out_det
);

  logic [ELEM_W-1:0] mat_rdata;
  logic [DET_W-1:0]  det_rdata;
  logic [DET_W-1:0]  acc;
  logic [DET_W-1:0]  prod;
  logic [DET_W-1:0]  minor_val;
  logic [ELEM_W+DET_W-1:0] prod_full;

  // Matrix element store, written in load order.
  mdc_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_mat_ram (
    .clk   (clk),
    .we    (cmd.mat_we),
    .waddr (cmd.mat_waddr),
    .wdata (elem_in),
    .raddr (cmd.mat_raddr),
    .rdata (mat_rdata)
  );

  // Minor determinants, indexed by column subset.
  mdc_ram #(.WIDTH(DET_W), .DEPTH(DET_DEPTH)) u_det_ram (
    .clk   (clk),
    .we    (cmd.det_we),
    .waddr (cmd.det_waddr),
    .wdata (acc),
    .raddr (cmd.det_raddr),
    .rdata (det_rdata)
  );

  // The empty minor has determinant one.
  assign minor_val = cmd.use_one ? DET_W'(1) : det_rdata;
  assign prod_full = $signed(mat_rdata) * $signed(minor_val);

  // Product register, then accumulator; all arithmetic wraps modulo 2^64.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= prod_full[DET_W-1:0];
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= cmd.acc_neg ? acc - prod : acc + prod;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_det <= acc;
    end
  end

  assign status.out_busy = out_valid;

endmodule

// ===== rtl/core/mdc_ctrl.sv =====
module mdc_ctrl
  import mdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  mdc_status_t status,
  output mdc_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_WAIT  = 7'b0000100,
    S_ACC   = 7'b0001000,
    S_STORE = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_MUL   = 7'b1000000
  } state_t;

  state_t              state, state_next;
  logic [2:0]          order_reg;
  logic [2:0]          n_eff;
  logic [MADDR_W-1:0]  load_count, load_count_next;
  logic [SUBSET_W-1:0] subset, subset_next;
  logic [COL_W-1:0]    col, col_next;
  logic                negate, negate_next;
  logic [MADDR_W-1:0]  total;
  logic [SUBSET_W-1:0] full_set;
  logic [SUBSET_W-1:0] col_bit;
  logic [SUBSET_W-1:0] minor_set;
  logic [2:0]          pop;
  logic [2:0]          row;
  logic                in_set;
  logic                accept;

  // Effective order: zero reads as one, above the maximum reads as the maximum.
  always_comb begin
    if (order_reg == 3'd0) begin
      n_eff = 3'd1;
    end else if (order_reg > 3'(MAX_ORDER)) begin
      n_eff = 3'(MAX_ORDER);
    end else begin
      n_eff = order_reg;
    end
  end

  // Subset bookkeeping: the row of the minor follows from the subset size.
  always_comb begin
    pop = '0;
    for (int i = 0; i < SUBSET_W; i++) begin
      pop = pop + 3'(subset[i]);
    end
  end

  assign total     = MADDR_W'(n_eff) * MADDR_W'(n_eff);
  assign full_set  = SUBSET_W'((7'd1 << n_eff) - 7'd1);
  assign col_bit   = SUBSET_W'(7'd1 << col);
  assign minor_set = subset & ~col_bit;
  assign in_set    = |(subset & col_bit);
  assign row       = n_eff - pop;
  assign in_ready  = (state == S_LOAD);
  assign accept    = in_valid && in_ready;

  // Order register and sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      order_reg  <= 3'(MAX_ORDER);
      state      <= S_LOAD;
      load_count <= '0;
      subset     <= '0;
      col        <= '0;
      negate     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        order_reg <= cfg_wdata;
      end
      state      <= state_next;
      load_count <= cfg_wen ? '0 : load_count_next;
      subset     <= subset_next;
      col        <= col_next;
      negate     <= negate_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    subset_next     = subset;
    col_next        = col;
    negate_next     = negate;
    cmd             = '0;
    cmd.mat_waddr   = load_count;
    cmd.mat_raddr   = MADDR_W'(row) * MADDR_W'(n_eff) + MADDR_W'(col);
    cmd.det_raddr   = minor_set;
    cmd.use_one     = (minor_set == '0);
    cmd.det_waddr   = subset;
    cmd.acc_neg     = negate;
    unique case (state)
      S_LOAD: begin
        if (accept) begin
          cmd.mat_we = 1'b1;
          if (load_count + 6'd1 >= total) begin
            load_count_next = '0;
            subset_next     = SUBSET_W'(1);
            col_next        = '0;
            negate_next     = 1'b0;
            cmd.acc_clr     = 1'b1;
            state_next      = S_SCAN;
          end else begin
            load_count_next = load_count + 6'd1;
          end
        end
      end
      S_SCAN: begin
        if (col >= n_eff) begin
          state_next = S_STORE;
        end else if (in_set) begin
          state_next = S_WAIT;
        end else begin
          col_next = col + 3'd1;
        end
      end
      S_WAIT: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en  = 1'b1;
        negate_next = !negate;
        col_next    = col + 3'd1;
        state_next  = S_SCAN;
      end
      S_STORE: begin
        cmd.det_we = 1'b1;
        if (subset == full_set) begin
          state_next = S_DONE;
        end else begin
          subset_next = subset + 6'd1;
          col_next    = '0;
          negate_next = 1'b0;
          cmd.acc_clr = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

`ifndef SYNTH
  a_store_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.det_we |-> subset != '0)
    else $error("minor stored for an empty subset");
  a_done_to_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !status.out_busy) |=> state == S_LOAD)
    else $error("finished result not handed over");
  a_mul_after_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_en |-> $past(state == S_WAIT))
    else $error("multiply without a read");
`endif

endmodule

// ===== rtl/core/matrix_determinant_cofactor.sv =====
// Channel   | Beat carries                       | Direction
// s_axis    | s_tdata[9:0] element (signed)      | in, one beat per element, row-major
// m_axis    | m_tdata[63:0] determinant (signed) | out, one beat per matrix
// cfg       | cfg_wdata[2:0] matrix_order        | in, write enable only
//
// Elements load one per cycle; the last element starts the expansion.
// The expansion builds every minor determinant over column subsets on a single
// 10x64 multiplier; each multiply-accumulate passes the scan, wait, multiply
// and accumulate states in turn.
// rst is synchronous and active high; it sets the order to six and empties the load.
// s_tready is low during the expansion; a waiting result holds the block in that state.
module matrix_determinant_cofactor
  import mdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] element, [15:10] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] determinant
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_wdata
);

  mdc_cmd_t    cmd;
  mdc_status_t status;

  // Sequencer.
  mdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Stores, multiplier and accumulator.
  mdc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .elem_in   (s_tdata[ELEM_W-1:0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_det   (m_tdata)
  );

endmodule

// ===== verif/tb_matrix_determinant_cofactor.sv =====
module tb_matrix_determinant_cofactor;
  import mdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 1500;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [9:0] element, [15:10] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // [63:0] determinant
  logic        cfg_wen;
  logic [2:0]  cfg_wdata;

  matrix_determinant_cofactor u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  // Predictor state: the loaded matrix, the fill count and the order.
  logic signed [ELEM_W-1:0] pred_store [STORE_DEPTH];
  int unsigned pred_count;
  logic [2:0]  pred_order;

  logic [ELEM_W-1:0] element_queue [$];
  logic [DET_W-1:0]  det_queue [$];
  int unsigned errors;
  int unsigned idle_cycles;
  logic        timed_out;
  logic        in_beat;

  always #5 clk = ~clk;

  // Clamp the order register to the supported range.
  function automatic int unsigned order_in_use(input logic [2:0] ord);
    if (ord == 3'd0) return 1;
    if (ord > MAX_ORDER) return MAX_ORDER;
    return ord;
  endfunction

  // Minor determinant over rows row..n-1 and the columns set in cols, modulo 2^64.
  function automatic logic [DET_W-1:0] minor_value(input int unsigned row,
                                                   input logic [7:0] cols,
                                                   input int unsigned n);
    logic [DET_W-1:0] acc;
    logic [DET_W-1:0] term;
    logic [DET_W-1:0] elem;
    logic             negate;
    acc = '0;
    negate = 1'b0;
    for (int c = 0; c < n; c++) begin
      if (cols[c]) begin
        elem = {{(DET_W-ELEM_W){pred_store[row*n+c][ELEM_W-1]}}, pred_store[row*n+c]};
        if (row + 1 >= n) return elem;
        term = elem * minor_value(row + 1, cols & ~(8'd1 << c), n);
        acc = negate ? acc - term : acc + term;
        negate = ~negate;
      end
    end
    return acc;
  endfunction

  // Load one element into the predictor and queue a determinant when the matrix is full.
  task automatic predict_element(input logic [ELEM_W-1:0] elem);
    int unsigned n;
    n = order_in_use(pred_order);
    if (pred_count >= n * n) pred_count = 0;
    pred_store[pred_count] = elem;
    pred_count++;
    if (pred_count == n * n) begin
      pred_count = 0;
      det_queue.push_back(minor_value(0, 8'((1 << n) - 1), n));
    end
  endtask

  function automatic int unsigned gap_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: presents queued elements, one beat at a time, with random gaps.
  int unsigned send_gap;
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      send_gap <= 0;
    end else if (!s_tvalid || in_beat) begin
      if (s_tvalid) begin
        // The beat was taken at the last rising edge; the next one waits its gap.
        s_tvalid <= 1'b0;
        send_gap <= gap_length();
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
      end else if (element_queue.size() != 0) begin
        s_tdata  <= {6'd0, element_queue.pop_front()};
        s_tvalid <= 1'b1;
      end
    end
  end

  // Receiver stalls at random.
  int unsigned stall_left;
  always @(negedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= gap_length();
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: follows order writes, predicts on accepted elements, checks determinants.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
      in_beat     <= 1'b0;
      errors      = 0;
      pred_count  = 0;
      pred_order  = 3'd6;
    end else begin
      in_beat <= s_tvalid && s_tready;
      if (cfg_wen) begin
        pred_order = cfg_wdata;
        pred_count = 0;
      end
      if (s_tvalid && s_tready) predict_element(s_tdata[ELEM_W-1:0]);
      if (m_tvalid && m_tready) begin
        if (det_queue.size() == 0) begin
          $display("%0t: unexpected determinant %0d", $realtime, $signed(m_tdata));
          errors++;
        end else begin
          if (m_tdata !== det_queue[0]) begin
            $display("%0t: determinant mismatch expected %0d actual %0d", $realtime,
                     $signed(det_queue[0]), $signed(m_tdata));
            errors++;
          end
          void'(det_queue.pop_front());
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk) begin
    if (rst) timed_out <= 1'b0;
    else if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
  end

  function automatic logic [ELEM_W-1:0] random_element();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 10'h200;
    if (pick == 1) return 10'h1FF;
    if (pick == 2) return ELEM_W'($urandom_range(0, 4) - 2);
    return ELEM_W'($urandom_range(0, 1023));
  endfunction

  // Wait until every element is taken and every determinant has arrived.
  task automatic drain();
    while (element_queue.size() != 0 || s_tvalid || det_queue.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Write the order register while the block is idle.
  task automatic write_order(input logic [2:0] ord);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= ord;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic queue_matrix(input int unsigned n, input int unsigned style);
    for (int i = 0; i < n * n; i++) begin
      case (style)
        0: element_queue.push_back(random_element());
        1: element_queue.push_back(10'h200);
        2: element_queue.push_back(10'h1FF);
        default: element_queue.push_back((i % (n + 1) == 0) ? 10'h200 : 10'h000);
      endcase
    end
  endtask

  int unsigned sent;
  logic [2:0]  ord;

  initial begin
    rst = 1'b1;
    cfg_wen = 1'b0; cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset order six with a diagonal of most-negative entries.
    queue_matrix(6, 3);
    drain();
    // Order one with the field extremes, order zero clamped, then order two with uniform extremes.
    write_order(3'd1);
    element_queue.push_back(10'h200);
    element_queue.push_back(10'h1FF);
    element_queue.push_back(10'h000);
    element_queue.push_back(10'h3FF);
    drain();
    write_order(3'd0);
    element_queue.push_back(10'h155);
    element_queue.push_back(10'h2AA);
    drain();
    write_order(3'd2);
    queue_matrix(2, 1);
    queue_matrix(2, 2);
    drain();
    // Order written in the middle of a load drops the partial matrix; order seven is clamped.
    write_order(3'd3);
    element_queue.push_back(10'h123);
    element_queue.push_back(10'h321);
    drain();
    write_order(3'd7);
    queue_matrix(6, 0);
    drain();

    // Random phases over all orders, mostly small ones.
    sent = 0;
    while (sent < 1000) begin
      ord = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
      write_order(ord);
      for (int m = 0; m < $urandom_range(2, 8); m++) begin
        queue_matrix(order_in_use(ord), 0);
        sent += order_in_use(ord) * order_in_use(ord);
      end
      // An occasional extra element, a partial load for the next register write to drop unless the order is one.
      if ($urandom_range(0, 4) == 0) begin
        element_queue.push_back(random_element());
        sent++;
      end
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && det_queue.size() == 0)
      $display("matrix_determinant_cofactor test passed");
    else
      $display("matrix_determinant_cofactor test failed");
    $finish;
  end

  // End the run on a stall.
  always @(posedge timed_out) begin
    $display("matrix_determinant_cofactor test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mdc_pkg.sv
rtl/core/mdc_ram.sv
rtl/core/mdc_dp.sv
rtl/core/mdc_ctrl.sv
rtl/core/matrix_determinant_cofactor.sv
verif/tb_matrix_determinant_cofactor.sv
